[rtl/core/scrl_pkg.sv]
// shared types and codes for the speculative counter rollback log
// used by scrl_ctrl, scrl_dpath and the top level; depends on nothing

package scrl_pkg;

   localparam int WORD_W = 32;

   // request kinds carried on req_tuser
   typedef enum logic [2:0] {
      ACT_INC    = 3'd0,
      ACT_DEC    = 3'd1,
      ACT_COMMIT = 3'd2,
      ACT_ABORT  = 3'd3,
      ACT_APPLY  = 3'd4,
      ACT_GET    = 3'd5
   } action_type;

   // result status carried on rsp_tuser
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_STALE    = 2'd2,
      STS_NOCOMMIT = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_EXEC,
      CMD_LOAD_SNAP,
      CMD_CMT_NONE,
      CMD_FWD_START,
      CMD_FWD_STEP,
      CMD_CMT_HIT,
      CMD_ABT_KEEP,
      CMD_ABT_ALL,
      CMD_BWD_START,
      CMD_BWD_STEP,
      CMD_ABT_HIT,
      CMD_RSP_LOAD
   } cmd_type;

   // datapath status seen by the controller
   typedef struct packed {
      action_type action;
      logic       fill_zero;
      logic       fill_one;
      logic       newest_lt;
      logic       hit_fwd;
      logic       hit_bwd;
      logic       chk_zero;
      logic       out_free;
   } stat_type;

endpackage

[rtl/core/scrl_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
// no dependencies

module scrl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/scrl_ctrl.sv]
// controller state machine for the rollback log: decode, log scans, response
// depends on scrl_pkg

module scrl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  scrl_pkg::stat_type  stat,
   output scrl_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FWD,
      ST_BWD,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = scrl_pkg::CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd      = scrl_pkg::CMD_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            unique case (stat.action)
               scrl_pkg::ACT_INC, scrl_pkg::ACT_DEC: begin
                  cmd = scrl_pkg::CMD_EXEC;
               end
               scrl_pkg::ACT_COMMIT: begin
                  if (stat.fill_zero || stat.newest_lt) begin
                     cmd = scrl_pkg::CMD_CMT_NONE;
                  end else begin
                     cmd      = scrl_pkg::CMD_FWD_START;
                     state_in = ST_FWD;
                  end
               end
               scrl_pkg::ACT_ABORT: begin
                  priority if (stat.fill_zero || stat.newest_lt) begin
                     cmd = scrl_pkg::CMD_ABT_KEEP;
                  end else if (stat.fill_one) begin
                     cmd = scrl_pkg::CMD_ABT_ALL;
                  end else begin
                     cmd      = scrl_pkg::CMD_BWD_START;
                     state_in = ST_BWD;
                  end
               end
               scrl_pkg::ACT_APPLY: begin
                  cmd = scrl_pkg::CMD_LOAD_SNAP;
               end
               default: begin
                  cmd = scrl_pkg::CMD_NONE;
               end
            endcase
         end
         // oldest-first search for the commit point
         ST_FWD: begin
            if (stat.hit_fwd) begin
               cmd      = scrl_pkg::CMD_CMT_HIT;
               state_in = ST_RESP;
            end else begin
               cmd = scrl_pkg::CMD_FWD_STEP;
            end
         end
         // newest-first search for the abort survivor
         ST_BWD: begin
            priority if (stat.hit_bwd) begin
               cmd      = scrl_pkg::CMD_ABT_HIT;
               state_in = ST_RESP;
            end else if (stat.chk_zero) begin
               cmd      = scrl_pkg::CMD_ABT_ALL;
               state_in = ST_RESP;
            end else begin
               cmd = scrl_pkg::CMD_BWD_STEP;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd      = scrl_pkg::CMD_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

[rtl/core/scrl_dpath.sv]
// datapath of the rollback log: counter, committed point, ring log and result register
// depends on scrl_pkg and scrl_ram

module scrl_dpath #(
   parameter int LOG_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  scrl_pkg::cmd_type   cmd,
   output scrl_pkg::stat_type  stat,
   input  logic [63:0]         req_tdata,  // index, snapshot_value
   input  logic [2:0]          req_tuser,  // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,  // value, seq
   output logic [1:0]          rsp_tuser   // status
);

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int FW = $clog2(LOG_DEPTH + 1);
   localparam int W  = scrl_pkg::WORD_W;
   localparam logic [FW:0]   DEPTH_W   = (FW+1)'(LOG_DEPTH);
   localparam logic [FW-1:0] FULL_FILL = FW'(LOG_DEPTH);
   localparam logic [FW-1:0] ONE_FILL  = FW'(1);
   localparam logic [FW-1:0] TWO_FILL  = FW'(2);

   // ring position of an offset from the oldest entry
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [FW-1:0] off);
      logic [FW:0] sum;
      sum = (FW+1)'(head) + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   scrl_pkg::action_type act_ff, act_in;
   scrl_pkg::status_type status_ff, status_in;
   logic [W-1:0]  idx_ff, idx_in;
   logic [W-1:0]  snap_ff, snap_in;
   logic [W-1:0]  cur_ff, cur_in;
   logic [W-1:0]  cidx_ff, cidx_in;
   logic [W-1:0]  ccnt_ff, ccnt_in;
   logic [W-1:0]  nidx_ff, nidx_in;
   logic [W-1:0]  nval_ff, nval_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] chk_ff;
   logic [AW-1:0] raddr_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_value_ff, rsp_value_in;
   logic [W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic [FW-1:0]  rd_off;
   logic [AW-1:0]  rd_addr;
   logic [2*W-1:0] rd_data;
   logic [W-1:0]   rd_idx;
   logic [W-1:0]   rd_cnt;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [2*W-1:0] wr_data;
   logic           exec_full;
   logic           exec_stale;
   logic [W-1:0]   count_step;

   assign rd_idx = rd_data[W-1:0];
   assign rd_cnt = rd_data[2*W-1:W];

   // scan offset selection
   always_comb begin
      unique case (cmd)
         scrl_pkg::CMD_FWD_START: rd_off = '0;
         scrl_pkg::CMD_FWD_STEP:  rd_off = chk_ff + ONE_FILL;
         scrl_pkg::CMD_BWD_START: rd_off = fill_ff - TWO_FILL;
         scrl_pkg::CMD_BWD_STEP:  rd_off = chk_ff - ONE_FILL;
         default:                 rd_off = chk_ff;
      endcase
   end

   assign rd_addr = slot(head_ff, rd_off);

   // append of a new change
   assign exec_full  = (fill_ff == FULL_FILL);
   assign exec_stale = (fill_ff != '0) && (idx_ff <= nidx_ff);
   assign count_step = (act_ff == scrl_pkg::ACT_INC) ? cur_ff + 1'b1 : cur_ff - 1'b1;
   assign wr_en      = (cmd == scrl_pkg::CMD_EXEC) && !exec_full && !exec_stale;
   assign wr_addr    = slot(head_ff, fill_ff);
   assign wr_data    = {count_step, idx_ff};

   scrl_ram #(
      .WIDTH(2 * W),
      .DEPTH(LOG_DEPTH)
   ) u_log (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // next state of the counter and log
   always_comb begin
      act_in        = act_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      snap_in       = snap_ff;
      cur_in        = cur_ff;
      cidx_in       = cidx_ff;
      ccnt_in       = ccnt_ff;
      nidx_in       = nidx_ff;
      nval_in       = nval_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_status_in = rsp_status_ff;
      unique case (cmd)
         scrl_pkg::CMD_CAPTURE: begin
            act_in    = scrl_pkg::action_type'(req_tuser);
            idx_in    = req_tdata[W-1:0];
            snap_in   = req_tdata[2*W-1:W];
            status_in = scrl_pkg::STS_OK;
         end
         scrl_pkg::CMD_EXEC: begin
            priority if (exec_full) begin
               status_in = scrl_pkg::STS_FULL;
            end else if (exec_stale) begin
               status_in = scrl_pkg::STS_STALE;
            end else begin
               cur_in  = count_step;
               nidx_in = idx_ff;
               nval_in = count_step;
               fill_in = fill_ff + ONE_FILL;
            end
         end
         scrl_pkg::CMD_LOAD_SNAP: begin
            cidx_in = idx_ff;
            ccnt_in = snap_ff;
            cur_in  = snap_ff;
            fill_in = '0;
            head_in = '0;
         end
         scrl_pkg::CMD_CMT_NONE: begin
            status_in = scrl_pkg::STS_NOCOMMIT;
         end
         scrl_pkg::CMD_CMT_HIT: begin
            cidx_in = rd_idx;
            ccnt_in = rd_cnt;
            head_in = raddr_ff;
            fill_in = fill_ff - chk_ff;
         end
         scrl_pkg::CMD_ABT_KEEP: begin
            cur_in = (fill_ff == '0) ? ccnt_ff : nval_ff;
         end
         scrl_pkg::CMD_ABT_ALL: begin
            fill_in = '0;
            cur_in  = ccnt_ff;
         end
         scrl_pkg::CMD_ABT_HIT: begin
            fill_in = chk_ff + ONE_FILL;
            nidx_in = rd_idx;
            nval_in = rd_cnt;
            cur_in  = rd_cnt;
         end
         scrl_pkg::CMD_RSP_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = (act_ff == scrl_pkg::ACT_GET) ?
                            ((fill_ff == '0) ? ccnt_ff : nval_ff) : cur_ff;
            rsp_seq_in    = (fill_ff == '0) ? cidx_ff : nidx_ff;
            rsp_status_in = status_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         cidx_ff      <= '0;
         ccnt_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         cidx_ff      <= cidx_in;
         ccnt_ff      <= ccnt_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      snap_ff       <= snap_in;
      nidx_ff       <= nidx_in;
      nval_ff       <= nval_in;
      chk_ff        <= rd_off;
      raddr_ff      <= rd_addr;
      rsp_value_ff  <= rsp_value_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_status_ff <= rsp_status_in;
   end

   // status toward the controller
   assign stat.action    = act_ff;
   assign stat.fill_zero = (fill_ff == '0);
   assign stat.fill_one  = (fill_ff == ONE_FILL);
   assign stat.newest_lt = (nidx_ff < idx_ff);
   assign stat.hit_fwd   = (rd_idx >= idx_ff);
   assign stat.hit_bwd   = (rd_idx < idx_ff);
   assign stat.chk_zero  = (chk_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_seq_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("log fill beyond depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      (FW+1)'(head_ff) < DEPTH_W)
      else $error("log head outside ring");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fill_ff != FULL_FILL))
      else $error("append into full log");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == scrl_pkg::CMD_RSP_LOAD) |-> stat.out_free)
      else $error("result overwritten before taken");

   a_commit_shrink: assert property (@(posedge clock) disable iff (reset)
      (cmd == scrl_pkg::CMD_CMT_HIT) |=> (fill_ff <= $past(fill_ff)) && (fill_ff != '0))
      else $error("commit did not keep a nonempty tail");

endmodule

[rtl/core/speculative_counter_rollback_log.sv]
// speculative counter with rollback log: controller and datapath
// requests enter on the req_ channel, results leave on the rsp_ channel; one result
// per transaction. action on req_tuser; index and snapshot_value on req_tdata.
// increment/decrement, apply snapshot, get snapshot and unused actions go through
// decode and result load from acceptance to result valid. commit and abort walk
// the log ring one entry per cycle through the registered read port of the log
// ram between decode and result load.
// a commit with no entry at or above the index, or an abort with nothing to drop,
// skips the scan. one transaction is worked on at a time; the next request is taken
// as soon as the previous result sits in the output register, even if not yet taken.
// if the receiver stalls, the result holds in rsp_tdata/rsp_tuser and the following
// transaction waits in its last step until the output register frees up.
// reset (synchronous, active high) zeroes the counter, committed point, head and fill;
// log ram contents are never cleared since only entries inside the fill are read.
// status: 0 ok, 1 log full, 2 index not above newest, 3 nothing to commit.

module speculative_counter_rollback_log #(
   parameter int LOG_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // index [31:0], snapshot_value [63:32]
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value [31:0], seq [63:32]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   scrl_pkg::cmd_type  cmd;
   scrl_pkg::stat_type stat;

   // sequencing of each transaction
   scrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counter, committed point and log storage
   scrl_dpath #(
      .LOG_DEPTH(LOG_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
